// ===== rtl/core/ksc_pkg.sv =====
package ksc_pkg;

  // fixed field widths of the request and result channels
  localparam int SYM_W       = 3;
  localparam int LEN_W       = 3;
  localparam int QSYM_W      = 18;
  localparam int CNT_W       = 32;
  localparam int QUERY_SLOTS = QSYM_W / SYM_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // request kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_ADD_DRAIN,
    ST_Q_ADDR,
    ST_Q_READ,
    ST_Q_DRAIN,
    ST_Q_DONE
  } ksc_state_t;

  // what the registered memory read data is for
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_BUMP,
    TAG_COUNT,
    TAG_VARIANT
  } ksc_tag_t;

endpackage

// ===== rtl/core/ksc_in_if.sv =====
interface ksc_in_if;

  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ksc_pkg::SYM_W-1:0]   symbol;
  logic                        restart;
  logic [ksc_pkg::LEN_W-1:0]   query_length;
  logic [ksc_pkg::QSYM_W-1:0]  query_symbols;

  modport source (
    output valid, kind, symbol, restart, query_length, query_symbols,
    input  ready
  );

  modport sink (
    input  valid, kind, symbol, restart, query_length, query_symbols,
    output ready
  );

endinterface

// ===== rtl/core/ksc_out_if.sv =====
interface ksc_out_if;

  logic                       valid;
  logic                       ready;
  logic [ksc_pkg::CNT_W-1:0]  string_count;
  logic [ksc_pkg::CNT_W-1:0]  variant_sum;

  modport source (
    output valid, string_count, variant_sum,
    input  ready
  );

  modport sink (
    input  valid, string_count, variant_sum,
    output ready
  );

endinterface

// ===== rtl/core/kmer_suffix_counter.sv =====
// channel   | dir | handshake           | payload
// ----------+-----+---------------------+---------------------------------------------
// in_req    | in  | valid/ready         | kind, symbol, restart, query_length, query_symbols
// out_res   | out | valid/ready         | string_count, variant_sum (one per query)
//
// After reset a clearing pass zeroes all (A^(K+1)-1)/(A-1) entries of the count memory
// (19531 with the defaults), one entry a cycle; no request is taken meanwhile.
// An add that completes a window goes through accept, K+1 read-modify-writes and a drain;
// other adds, dropped symbols included, end with the accept.
// A query: accept, L+1 address steps, A reads, drain, result load; an empty query reads once,
// too long a query not at all; only a query stalls behind a held result.
module kmer_suffix_counter #(
  parameter int WINDOW_LENGTH = 6,
  parameter int ALPHABET_SIZE = 5
) (
  input logic    clk,
  input logic    rst_n,
  ksc_in_if.sink   in_req,
  ksc_out_if.source out_res
);

  import ksc_pkg::*;

  function automatic int store_depth(input int k, input int a);
    int p;
    int s;
    p = 1;
    s = 0;
    for (int i = 0; i <= k; i++) begin
      s = s + p;
      p = p * a;
    end
    return s;
  endfunction

  localparam int DEPTH    = store_depth(WINDOW_LENGTH, ALPHABET_SIZE);
  localparam int AW       = $clog2(DEPTH);
  localparam int STEP_MAX = (WINDOW_LENGTH > ALPHABET_SIZE) ? WINDOW_LENGTH : ALPHABET_SIZE;
  localparam int STEP_W   = $clog2(STEP_MAX + 1);
  localparam int FILL_W   = $clog2(WINDOW_LENGTH + 1);
  localparam int WIN_IW   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

  // symbol at a string position, zero past the query field
  function automatic logic [SYM_W-1:0] query_sym_at(input logic [QSYM_W-1:0] q,
                                                    input logic [LEN_W-1:0]  pos);
    logic [SYM_W-1:0] s;
    s = '0;
    if (pos < LEN_W'(QUERY_SLOTS)) begin
      s = q[SYM_W*pos +: SYM_W];
    end
    return s;
  endfunction

  // control state
  ksc_state_t        state_r, state_nxt;
  logic [AW-1:0]     acc_r, acc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SYM_W-1:0]  win_r   [WINDOW_LENGTH];
  logic [SYM_W-1:0]  win_nxt [WINDOW_LENGTH];
  logic              out_valid_r, out_valid_nxt;
  ksc_tag_t          rd_tag_r, rd_tag_nxt;

  // datapath registers
  logic [AW-1:0]     pw_r, pw_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [LEN_W-1:0]  qlen_r, qlen_nxt;
  logic [QSYM_W-1:0] qsym_r, qsym_nxt;
  logic              qbad_r, qbad_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic [CNT_W-1:0]  out_sum_r, out_sum_nxt;

  // count memory
  logic [CNT_W-1:0]  count_mem [DEPTH];
  logic [CNT_W-1:0]  rdata_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CNT_W-1:0]  mem_wdata;

  // shared multiply-add unit and helpers
  logic [3:0]        unit_dig;
  logic [AW-1:0]     unit_sum;
  logic [AW-1:0]     pw_scaled;
  logic [WIN_IW-1:0] win_idx;
  logic [SYM_W-1:0]  win_sel;
  logic [LEN_W-1:0]  qpos;
  logic [SYM_W-1:0]  qrev;
  logic [SYM_W-1:0]  qrev0;
  logic              qrev0_ok;
  logic [FILL_W-1:0] fill_base;
  logic [CNT_W:0]    sum_ext;

  // address unit: acc + pw * digit, pw scaled by the alphabet each step
  assign unit_sum  = AW'(acc_r + pw_r * unit_dig);
  assign pw_scaled = AW'(pw_r * AW'(ALPHABET_SIZE));

  // window symbol for the current step
  assign win_idx = (step_r < STEP_W'(WINDOW_LENGTH)) ? step_r[WIN_IW-1:0] : '0;
  assign win_sel = win_r[win_idx];

  // query symbol the current step back from the string end, and the last symbol
  assign qpos     = LEN_W'(qlen_r - LEN_W'(1) - LEN_W'(step_r));
  assign qrev     = query_sym_at(qsym_r, qpos);
  assign qrev0    = query_sym_at(qsym_r, LEN_W'(qlen_r - LEN_W'(1)));
  assign qrev0_ok = {1'b0, qrev0} < (SYM_W+1)'(ALPHABET_SIZE);

  assign sum_ext = {1'b0, sum_r} + {1'b0, rdata_r};

  // add request: fill count after an optional restart
  assign fill_base = in_req.restart ? '0 : fill_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    rd_tag_nxt    = TAG_NONE;
    pw_nxt        = pw_r;
    step_nxt      = step_r;
    qlen_nxt      = qlen_r;
    qsym_nxt      = qsym_r;
    qbad_nxt      = qbad_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    wa_nxt        = wa_r;
    out_count_nxt = out_count_r;
    out_sum_nxt   = out_sum_r;
    unit_dig      = '0;
    mem_we        = 1'b0;
    mem_waddr     = wa_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = acc_r;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      win_nxt[i] = win_r[i];
    end

    // result taken downstream
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    // write-back of the previous cycle's read
    case (rd_tag_r)
      TAG_BUMP: begin
        mem_we    = 1'b1;
        mem_wdata = (rdata_r == CNT_MAX) ? rdata_r : rdata_r + CNT_W'(1);
      end
      TAG_COUNT: begin
        cnt_nxt = rdata_r;
      end
      TAG_VARIANT: begin
        sum_nxt = sum_ext[CNT_W] ? CNT_MAX : sum_ext[CNT_W-1:0];
      end
      default: begin
      end
    endcase

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = acc_r;
        mem_wdata = '0;
        acc_nxt   = AW'(acc_r + AW'(1));
        if (acc_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_req.valid) begin
          acc_nxt  = '0;
          pw_nxt   = AW'(1);
          step_nxt = '0;
          if (in_req.kind == KIND_ADD) begin
            // invalid symbols are dropped entirely
            if ({1'b0, in_req.symbol} < (SYM_W+1)'(ALPHABET_SIZE)) begin
              for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
                win_nxt[i] = win_r[i-1];
              end
              win_nxt[0] = in_req.symbol;
              if (fill_base < FILL_W'(WINDOW_LENGTH)) begin
                fill_nxt = FILL_W'(fill_base + FILL_W'(1));
              end else begin
                fill_nxt = fill_base;
              end
              if (fill_nxt == FILL_W'(WINDOW_LENGTH)) begin
                state_nxt = ST_ADD;
              end
            end
          end else begin
            qlen_nxt = in_req.query_length;
            qsym_nxt = in_req.query_symbols;
            qbad_nxt = 1'b0;
            cnt_nxt  = '0;
            sum_nxt  = '0;
            if ({1'b0, in_req.query_length} > (LEN_W+1)'(WINDOW_LENGTH)) begin
              state_nxt = ST_Q_DONE;
            end else begin
              state_nxt = ST_Q_ADDR;
            end
          end
        end
      end

      // read-modify-write of the empty string and every window suffix
      ST_ADD: begin
        mem_re     = 1'b1;
        mem_raddr  = acc_r;
        rd_tag_nxt = TAG_BUMP;
        wa_nxt     = acc_r;
        unit_dig   = 4'({1'b0, win_sel} + 4'd1);
        if (step_r == STEP_W'(WINDOW_LENGTH)) begin
          state_nxt = ST_ADD_DRAIN;
        end else begin
          acc_nxt  = unit_sum;
          pw_nxt   = pw_scaled;
          step_nxt = STEP_W'(step_r + STEP_W'(1));
        end
      end

      ST_ADD_DRAIN: begin
        state_nxt = ST_IDLE;
      end

      // node base of the string without its last symbol
      ST_Q_ADDR: begin
        if (step_r == STEP_W'(qlen_r)) begin
          state_nxt = ST_Q_READ;
          step_nxt  = '0;
        end else begin
          if (step_r != '0) begin
            unit_dig = 4'({1'b0, qrev} + 4'd1);
            if ({1'b0, qrev} >= (SYM_W+1)'(ALPHABET_SIZE)) begin
              qbad_nxt = 1'b1;
            end
          end
          acc_nxt  = unit_sum;
          pw_nxt   = pw_scaled;
          step_nxt = STEP_W'(step_r + STEP_W'(1));
        end
      end

      // string count first, then the variants of the last symbol from 0 to A-2
      ST_Q_READ: begin
        if (step_r == '0) begin
          if (qlen_r == '0) begin
            mem_re     = 1'b1;
            mem_raddr  = acc_r;
            rd_tag_nxt = TAG_COUNT;
            state_nxt  = ST_Q_DRAIN;
          end else begin
            if (!qbad_r && qrev0_ok) begin
              mem_re     = 1'b1;
              mem_raddr  = AW'(acc_r + AW'(qrev0) + AW'(1));
              rd_tag_nxt = TAG_COUNT;
            end
            step_nxt = STEP_W'(step_r + STEP_W'(1));
          end
        end else begin
          if (!qbad_r) begin
            mem_re     = 1'b1;
            mem_raddr  = AW'(acc_r + AW'(step_r));
            rd_tag_nxt = TAG_VARIANT;
          end
          if (step_r == STEP_W'(ALPHABET_SIZE - 1)) begin
            state_nxt = ST_Q_DRAIN;
          end else begin
            step_nxt = STEP_W'(step_r + STEP_W'(1));
          end
        end
      end

      ST_Q_DRAIN: begin
        state_nxt = ST_Q_DONE;
      end

      ST_Q_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_r;
          out_sum_nxt   = sum_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      acc_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      rd_tag_r    <= TAG_NONE;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      rd_tag_r    <= rd_tag_nxt;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pw_r        <= pw_nxt;
    step_r      <= step_nxt;
    qlen_r      <= qlen_nxt;
    qsym_r      <= qsym_nxt;
    qbad_r      <= qbad_nxt;
    cnt_r       <= cnt_nxt;
    sum_r       <= sum_nxt;
    wa_r        <= wa_nxt;
    out_count_r <= out_count_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  // count memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= count_mem[mem_raddr];
    end
  end

  // channel outputs
  assign in_req.ready         = (state_r == ST_IDLE);
  assign out_res.valid        = out_valid_r;
  assign out_res.string_count = out_count_r;
  assign out_res.variant_sum  = out_sum_r;

  // checks
  a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same counter in one cycle");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_waddr <= AW'(DEPTH - 1)))
    else $error("count memory write beyond the store");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_LENGTH))
    else $error("window fill above window length");

  a_idle_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> (rd_tag_r == TAG_NONE))
    else $error("request taken while a memory read is still in flight");

endmodule
